// File: sv/bdec_pkg.sv
// Shared types and constants for the debounced button edge counter.
// No dependencies; imported by the top level, bdec_cfg and bdec_core.
package bdec_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [FUNC_W-1:0]     t_func;
    typedef logic [MODE_W-1:0]     t_mode;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_func FUNC_DEBOUNCE     = 2'd0;
    localparam t_func FUNC_DOUBLE_CLICK = 2'd1;
    localparam t_func FUNC_CLEAR        = 2'd2;
    localparam t_func FUNC_NONE         = 2'd3;

    localparam t_mode MODE_BOTH    = 2'd0;
    localparam t_mode MODE_FALLING = 2'd1;
    localparam t_mode MODE_RISING  = 2'd2;
    localparam t_mode MODE_NONE    = 2'd3;

    localparam t_cfg_idx REG_DEBOUNCE_MS     = 2'd0;
    localparam t_cfg_idx REG_COUNT_MODE      = 2'd1;
    localparam t_cfg_idx REG_DOUBLE_CLICK_MS = 2'd2;

    localparam logic [MS_W-1:0] DEBOUNCE_MS_RESET     = 16'd0;
    localparam t_mode           COUNT_MODE_RESET      = MODE_FALLING;
    localparam logic [MS_W-1:0] DOUBLE_CLICK_MS_RESET = 16'd500;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        t_mode           count_mode;
        logic [MS_W-1:0] double_click_ms;
    } t_cfg;

    typedef struct packed {
        logic               stable_level;
        logic               pressed;
        logic               released;
        logic [COUNT_W-1:0] edge_count;
        logic               double_click;
    } t_result;

endpackage

// File: sv/button_debounce_edge_counter.sv
// Top level of the debounced button edge counter: input register, result register.
// Depends on bdec_pkg, bdec_cfg and bdec_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one sample: operation code,
//   raw pin level and a millisecond timestamp. Output channel (o_out_valid /
//   i_out_stall) returns exactly one result per sample, in order.
//   A sample is registered on transfer into the input register and processed
//   when the result register can take it: the state registers and the result
//   register then update together and o_out_valid rises.
//   Throughput is one sample per cycle while the receiver does not stall, set by the single state-update step.
//   When the receiver stalls, the result register holds; the input register
//   takes one more sample, then o_in_stall rises until the result leaves.
//   Reset (synchronous, i_rst_n low) empties both registers, sets the raw and
//   stable levels high, clears times, count and click tracking, and restores
//   the configuration registers to their reset values.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
//   must write it only while no sample is in flight, as the block does not enforce it.
module button_debounce_edge_counter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  bdec_pkg::t_func         i_func,
    input  logic                    i_pin_level,
    input  logic [31:0]             i_now_ms,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_stable_level,
    output logic                    o_pressed,
    output logic                    o_released,
    output logic [31:0]             o_edge_count,
    output logic                    o_double_click,
    input  logic                    i_cfg_we,
    input  bdec_pkg::t_cfg_idx      i_cfg_index,
    input  bdec_pkg::t_cfg_data     i_cfg_data
);
    import bdec_pkg::*;

    logic              r_in_valid;
    t_func             r_func;
    logic              r_pin_level;
    logic [TIME_W-1:0] r_now_ms;
    logic              r_out_valid;
    t_result           r_result;

    logic    in_xfer;
    logic    fire;
    t_cfg    cfg;
    t_result result;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_xfer    = i_in_valid && !o_in_stall;

    bdec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bdec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_func      (r_func),
        .i_pin_level (r_pin_level),
        .i_now_ms    (r_now_ms),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func      <= i_func;
            r_pin_level <= i_pin_level;
            r_now_ms    <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_stable_level = r_result.stable_level;
    assign o_pressed      = r_result.pressed;
    assign o_released     = r_result.released;
    assign o_edge_count   = r_result.edge_count;
    assign o_double_click = r_result.double_click;

endmodule

// File: sv/bdec_cfg.sv
// Configuration register file for the debounced button edge counter.
// Depends on bdec_pkg.
module bdec_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  bdec_pkg::t_cfg_idx i_cfg_index,
    input  bdec_pkg::t_cfg_data i_cfg_data,
    output bdec_pkg::t_cfg     o_cfg
);
    import bdec_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= DEBOUNCE_MS_RESET;
            r_cfg.count_mode      <= COUNT_MODE_RESET;
            r_cfg.double_click_ms <= DOUBLE_CLICK_MS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE_MS: begin
                    r_cfg.debounce_ms <= i_cfg_data[MS_W-1:0];
                end
                REG_COUNT_MODE: begin
                    r_cfg.count_mode <= i_cfg_data[MODE_W-1:0];
                end
                REG_DOUBLE_CLICK_MS: begin
                    r_cfg.double_click_ms <= i_cfg_data[MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/bdec_core.sv
// Button state registers and the per-item update logic: debounce, edge count,
// double-click window and clear. Depends on bdec_pkg.
module bdec_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  bdec_pkg::t_func        i_func,
    input  logic                   i_pin_level,
    input  logic [31:0]            i_now_ms,
    input  bdec_pkg::t_cfg         i_cfg,
    output bdec_pkg::t_result      o_result
);
    import bdec_pkg::*;

    logic               r_raw_last;
    logic               r_stable_prev;
    logic               r_stable_now;
    logic [TIME_W-1:0]  r_change_time;
    logic [COUNT_W-1:0] r_edge_total;
    logic               r_first_seen;
    logic [TIME_W-1:0]  r_first_time;

    logic               n_raw_last;
    logic               n_stable_prev;
    logic               n_stable_now;
    logic [TIME_W-1:0]  n_change_time;
    logic [COUNT_W-1:0] n_edge_total;
    logic               n_first_seen;
    logic [TIME_W-1:0]  n_first_time;
    logic               n_hit;

    logic               raw_change;
    logic [TIME_W-1:0]  db_change_time;
    logic [TIME_W-1:0]  db_elapsed;
    logic               db_shift;
    logic               db_prev;
    logic               db_now;
    logic               db_fall;
    logic               db_rise;
    logic               db_count;
    logic               dc_seen;
    logic [TIME_W-1:0]  dc_time;
    logic               dc_hit;
    logic [TIME_W-1:0]  dc_elapsed;
    logic [TIME_W-1:0]  dc_window;

    assign raw_change = (i_pin_level != r_raw_last);
    assign dc_window  = {{(TIME_W-MS_W){1'b0}}, i_cfg.double_click_ms};

    // debounce path
    always_comb begin
        db_change_time = raw_change ? i_now_ms : r_change_time;
        db_elapsed     = i_now_ms - db_change_time;
        db_shift       = (db_elapsed >= {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms});
        db_prev        = db_shift ? r_stable_now : r_stable_prev;
        db_now         = db_shift ? i_pin_level  : r_stable_now;
        db_fall        = db_prev && !db_now;
        db_rise        = !db_prev && db_now;
        unique case (i_cfg.count_mode)
            MODE_BOTH:    db_count = db_fall || db_rise;
            MODE_FALLING: db_count = db_fall;
            MODE_RISING:  db_count = db_rise;
            default:      db_count = 1'b0;
        endcase
    end

    // double-click path
    always_comb begin
        dc_seen = r_first_seen;
        dc_time = r_first_time;
        dc_hit  = 1'b0;
        if (raw_change && !i_pin_level) begin
            if (!r_first_seen) begin
                dc_seen = 1'b1;
                dc_time = i_now_ms;
            end else if ((i_now_ms - r_first_time) <= dc_window) begin
                dc_hit  = 1'b1;
                dc_seen = 1'b0;
            end
        end
        dc_elapsed = i_now_ms - dc_time;
        if (dc_seen && (dc_elapsed > dc_window)) begin
            dc_seen = 1'b0;
        end
    end

    always_comb begin
        n_raw_last    = r_raw_last;
        n_stable_prev = r_stable_prev;
        n_stable_now  = r_stable_now;
        n_change_time = r_change_time;
        n_edge_total  = r_edge_total;
        n_first_seen  = r_first_seen;
        n_first_time  = r_first_time;
        n_hit         = 1'b0;
        unique case (i_func)
            FUNC_DEBOUNCE: begin
                n_raw_last    = i_pin_level;
                n_change_time = db_change_time;
                n_stable_prev = db_prev;
                n_stable_now  = db_now;
                n_edge_total  = r_edge_total + COUNT_W'(db_count);
            end
            FUNC_DOUBLE_CLICK: begin
                n_raw_last   = i_pin_level;
                n_first_seen = dc_seen;
                n_first_time = dc_time;
                n_hit        = dc_hit;
            end
            FUNC_CLEAR: begin
                n_edge_total = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_last    <= 1'b1;
            r_stable_prev <= 1'b1;
            r_stable_now  <= 1'b1;
            r_change_time <= '0;
            r_edge_total  <= '0;
            r_first_seen  <= 1'b0;
            r_first_time  <= '0;
        end else if (i_fire) begin
            r_raw_last    <= n_raw_last;
            r_stable_prev <= n_stable_prev;
            r_stable_now  <= n_stable_now;
            r_change_time <= n_change_time;
            r_edge_total  <= n_edge_total;
            r_first_seen  <= n_first_seen;
            r_first_time  <= n_first_time;
        end
    end

    always_comb begin
        o_result.stable_level = n_stable_now;
        o_result.pressed      = n_stable_prev && !n_stable_now;
        o_result.released     = !n_stable_prev && n_stable_now;
        o_result.edge_count   = n_edge_total;
        o_result.double_click = n_hit;
    end

endmodule

// File: sv/bdec_checker.sv
// Port-level checks for the debounced button edge counter, bound to the top level.
// Depends on button_debounce_edge_counter.
module bdec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        o_stable_level,
    input  logic        o_pressed,
    input  logic        o_released,
    input  logic [31:0] o_edge_count,
    input  logic        o_double_click
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_edge_count)
            && $stable(o_stable_level) && $stable(o_double_click))
        else $error("stalled result changed");

    a_press_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pressed |-> !o_stable_level && !o_released)
        else $error("press flag with high stable level");

    a_release_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_released |-> o_stable_level)
        else $error("release flag with low stable level");

    a_stall_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output side is free");

endmodule

bind button_debounce_edge_counter bdec_checker u_bdec_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_stable_level (o_stable_level),
    .o_pressed      (o_pressed),
    .o_released     (o_released),
    .o_edge_count   (o_edge_count),
    .o_double_click (o_double_click)
);
